// ----- src/rfidseq_pkg.sv -----
// Package for the RFID reader I2C sequencer: item and result structs,
// operation, bus command and sequence step codes, buffer sizing.
// No dependencies.
`timescale 1ns / 1ps

package rfidseq_pkg;

	localparam int BUF_DEPTH = 8;
	localparam int IDX_W     = 3;
	localparam int LEN_W     = 4;

	localparam logic [LEN_W-1:0] BUF_LEN_MAX    = LEN_W'(BUF_DEPTH);
	localparam logic [6:0]       DEV_ADDR_RESET = 7'h50;
	localparam logic [7:0]       REG_PARAM      = 8'h00;
	localparam logic [7:0]       REG_FRAME      = 8'h01;

	typedef enum logic [2:0] {
		OP_BUS_READY   = 3'd0,
		OP_READ_PARAM  = 3'd1,
		OP_WRITE_PARAM = 3'd2,
		OP_READ_FRAME  = 3'd3,
		OP_WRITE_FRAME = 3'd4,
		OP_LOAD_BYTE   = 3'd5,
		OP_FETCH_BYTE  = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		CMD_NONE      = 4'd0,
		CMD_START     = 4'd1,
		CMD_RESTART   = 4'd2,
		CMD_STOP      = 4'd3,
		CMD_ADDR_WR   = 4'd4,
		CMD_ADDR_RD   = 4'd5,
		CMD_WRITE     = 4'd6,
		CMD_READ_ACK  = 4'd7,
		CMD_READ_NACK = 4'd8
	} cmd_t;

	// Sequence steps, one-hot. RP: read param, WP: write param,
	// RF: read frame, WF: write frame.
	typedef enum logic [29:0] {
		ST_IDLE = 30'd1 << 0,
		ST_RP0  = 30'd1 << 1,
		ST_RP1  = 30'd1 << 2,
		ST_RP2  = 30'd1 << 3,
		ST_RP3  = 30'd1 << 4,
		ST_RP4  = 30'd1 << 5,
		ST_RP5  = 30'd1 << 6,
		ST_RP6  = 30'd1 << 7,
		ST_WP0  = 30'd1 << 8,
		ST_WP1  = 30'd1 << 9,
		ST_WP2  = 30'd1 << 10,
		ST_WP3  = 30'd1 << 11,
		ST_WP4  = 30'd1 << 12,
		ST_RF0  = 30'd1 << 13,
		ST_RF1  = 30'd1 << 14,
		ST_RF2  = 30'd1 << 15,
		ST_RF3  = 30'd1 << 16,
		ST_RF4  = 30'd1 << 17,
		ST_RF5  = 30'd1 << 18,
		ST_RF6  = 30'd1 << 19,
		ST_RF7  = 30'd1 << 20,
		ST_RF8  = 30'd1 << 21,
		ST_RF9  = 30'd1 << 22,
		ST_RF10 = 30'd1 << 23,
		ST_WF0  = 30'd1 << 24,
		ST_WF1  = 30'd1 << 25,
		ST_WF2  = 30'd1 << 26,
		ST_WF3  = 30'd1 << 27,
		ST_WF4  = 30'd1 << 28,
		ST_WF5  = 30'd1 << 29
	} step_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] host_byte;
		logic [2:0] buffer_slot;
		logic [7:0] send_length;
		logic [7:0] received_byte;
		logic       slave_acked;
	} item_t;

	typedef struct packed {
		logic [3:0]       bus_command;
		logic [7:0]       bus_byte;
		logic             busy_res;
		logic             nack_seen;
		logic [7:0]       fetched_byte;
		logic [LEN_W-1:0] frame_count;
	} result_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [7:0] v);
		logic [LEN_W-1:0] r;
		if (v > 8'(BUF_DEPTH)) begin
			r = BUF_LEN_MAX;
		end else begin
			r = v[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/rfid_reader_i2c_sequencer_top.sv -----
// Top level of the RFID reader I2C sequencer.
// Depends on rfidseq_pkg.
`timescale 1ns / 1ps

// I2C transaction sequencer for an RFID reader chip. The host issues one of
// four transactions (read or write the parameter register, read or write a
// frame) and then steps the sequence with bus_ready items; each step returns
// the next bus primitive (start, restart, stop, address, write byte, read with
// ACK or NACK) or none for a bookkeeping step. A new command replaces any
// sequence in progress; load_byte and fetch_byte access the eight-byte frame
// buffer by slot without disturbing it. Slot 0 doubles as the parameter byte.
// Frame lengths, received or requested, are clamped to eight. nack_seen flags
// the stop step of a write transaction whose last byte was not acknowledged.
// Rate: one item per clock, sustained while the result side does not stall. An
// accepted item is held in the input register, and its result is written to the
// output register once that register is free, from where it is offered. The
// rate is set by the update of the step, length and position registers as
// each item fires. Once both registers are
// full, stall on the result side propagates to item_stall in the same cycle;
// the output register holds a stalled result unchanged.
// device_address (reset 0x50) is written through cfg_wr_en / cfg_wr_data
// and must only change while the block is idle. Frame buffer bytes are not
// cleared at reset: write a slot before reading it.

module rfid_reader_i2c_sequencer_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [6:0]           cfg_wr_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  rfidseq_pkg::item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output rfidseq_pkg::result_t result
);
	import rfidseq_pkg::*;

	// Pipeline registers
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;

	// Sequencer state
	step_t            step_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] pos_q;
	logic [6:0]       addr_q;
	logic [7:0]       buf_q [BUF_DEPTH];

	// Next-state and result logic
	step_t            nxt_step;
	logic [LEN_W-1:0] nxt_len;
	logic [LEN_W-1:0] nxt_pos;
	logic [LEN_W-1:0] pos_inc;
	logic [LEN_W-1:0] rx_len;
	logic [3:0]       cmd;
	logic [7:0]       bbyte;
	logic             nack;
	logic [7:0]       fetched;
	logic             buf_we;
	logic [IDX_W-1:0] buf_widx;
	logic [7:0]       buf_wdata;
	logic [IDX_W-1:0] rd_idx;
	logic [7:0]       buf_rd;
	result_t          res_d;

	logic out_free;
	logic fire_s1;
	logic accept;

	// Handshake: the output register frees when it is empty or being drained
	assign out_free   = !valid_s2 || !result_stall;
	assign fire_s1    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Single buffer read port: fetch by slot, parameter byte, or frame position
	assign rd_idx = (item_s1.operation == OP_FETCH_BYTE) ? item_s1.buffer_slot :
	                (step_q == ST_WP3)                   ? IDX_W'(0) :
	                                                       pos_q[IDX_W-1:0];
	assign buf_rd  = buf_q[rd_idx];
	assign pos_inc = pos_q + LEN_W'(1);
	assign rx_len  = clamp_len(item_s1.received_byte);

	always_comb begin
		nxt_step  = step_q;
		nxt_len   = len_q;
		nxt_pos   = pos_q;
		cmd       = CMD_NONE;
		bbyte     = 8'h00;
		nack      = 1'b0;
		fetched   = 8'h00;
		buf_we    = 1'b0;
		buf_widx  = '0;
		buf_wdata = item_s1.host_byte;
		unique case (item_s1.operation)
			OP_READ_PARAM: begin
				nxt_step = ST_RP0;
			end
			OP_WRITE_PARAM: begin
				buf_we   = 1'b1;
				nxt_step = ST_WP0;
			end
			OP_READ_FRAME: begin
				nxt_step = ST_RF0;
			end
			OP_WRITE_FRAME: begin
				nxt_len  = clamp_len(item_s1.send_length);
				nxt_step = ST_WF0;
			end
			OP_LOAD_BYTE: begin
				buf_we   = 1'b1;
				buf_widx = item_s1.buffer_slot;
			end
			OP_FETCH_BYTE: begin
				fetched = buf_rd;
			end
			OP_BUS_READY: begin
				unique case (step_q)
					ST_IDLE: begin
						nxt_step = ST_IDLE;
					end
					ST_RP0, ST_WP0, ST_RF0, ST_WF0: begin
						cmd      = CMD_START;
						nxt_step = step_t'(step_q << 1);
					end
					ST_RP1, ST_WP1, ST_RF1, ST_WF1: begin
						cmd      = CMD_ADDR_WR;
						bbyte    = {1'b0, addr_q};
						nxt_step = step_t'(step_q << 1);
					end
					ST_RP4, ST_RF4: begin
						cmd      = CMD_ADDR_RD;
						bbyte    = {1'b0, addr_q};
						nxt_step = step_t'(step_q << 1);
					end
					ST_RP2, ST_WP2: begin
						cmd      = CMD_WRITE;
						bbyte    = REG_PARAM;
						nxt_step = step_t'(step_q << 1);
					end
					ST_RF2, ST_WF2: begin
						cmd      = CMD_WRITE;
						bbyte    = REG_FRAME;
						nxt_step = step_t'(step_q << 1);
					end
					ST_RP3, ST_RF3: begin
						cmd      = CMD_RESTART;
						nxt_step = step_t'(step_q << 1);
					end
					ST_RP5: begin
						cmd      = CMD_READ_NACK;
						nxt_step = ST_RP6;
					end
					ST_RP6: begin
						buf_we    = 1'b1;
						buf_wdata = item_s1.received_byte;
						cmd       = CMD_STOP;
						nxt_step  = ST_IDLE;
					end
					ST_WP3: begin
						cmd      = CMD_WRITE;
						bbyte    = buf_rd;
						nxt_step = ST_WP4;
					end
					ST_WP4, ST_WF5: begin
						nack     = !item_s1.slave_acked;
						cmd      = CMD_STOP;
						nxt_step = ST_IDLE;
					end
					ST_RF5: begin
						cmd      = CMD_READ_ACK;
						nxt_step = ST_RF6;
					end
					ST_RF6: begin
						// length byte just read
						nxt_len = rx_len;
						if (rx_len == '0) begin
							nxt_step = ST_RF9;
						end else begin
							nxt_pos  = '0;
							nxt_step = ST_RF7;
						end
					end
					ST_RF7: begin
						if (pos_q < len_q) begin
							cmd      = (pos_inc < len_q) ? CMD_READ_ACK : CMD_READ_NACK;
							nxt_step = ST_RF8;
						end else begin
							nxt_step = ST_RF10;
						end
					end
					ST_RF8: begin
						buf_we    = (pos_q < BUF_LEN_MAX);
						buf_widx  = pos_q[IDX_W-1:0];
						buf_wdata = item_s1.received_byte;
						nxt_pos   = pos_inc;
						nxt_step  = ST_RF7;
					end
					ST_RF9: begin
						// zero length: one dummy read
						cmd      = CMD_READ_NACK;
						nxt_step = ST_RF10;
					end
					ST_RF10: begin
						cmd      = CMD_STOP;
						nxt_step = ST_IDLE;
					end
					ST_WF3: begin
						cmd      = CMD_WRITE;
						bbyte    = 8'(len_q);
						nxt_pos  = '0;
						nxt_step = ST_WF4;
					end
					ST_WF4: begin
						if (pos_q < len_q) begin
							cmd     = CMD_WRITE;
							bbyte   = buf_rd;
							nxt_pos = pos_inc;
						end else begin
							nxt_step = ST_WF5;
						end
					end
					default: begin
						nxt_step = ST_IDLE;
					end
				endcase
			end
			default: begin
				nxt_step = step_q;
			end
		endcase

		res_d.bus_command  = cmd;
		res_d.bus_byte     = bbyte;
		res_d.busy_res     = (nxt_step != ST_IDLE);
		res_d.nack_seen    = nack;
		res_d.fetched_byte = fetched;
		res_d.frame_count  = nxt_len;
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			step_q   <= ST_IDLE;
			len_q    <= '0;
			pos_q    <= '0;
			addr_q   <= DEV_ADDR_RESET;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1) begin
				step_q <= nxt_step;
				len_q  <= nxt_len;
				pos_q  <= nxt_pos;
			end
			if (cfg_wr_en) begin
				addr_q <= cfg_wr_data;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire_s1) begin
			result_s2 <= res_d;
		end
		if (fire_s1 && buf_we) begin
			buf_q[buf_widx] <= buf_wdata;
		end
	end

endmodule

// ----- src/rfidseq_checker.sv -----
// Port-level checker for the RFID reader I2C sequencer, bound to the top level.
// Depends on rfidseq_pkg and rfid_reader_i2c_sequencer_top.
`timescale 1ns / 1ps

module rfidseq_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input rfidseq_pkg::result_t result
);
	import rfidseq_pkg::*;

	// stalled transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_nack_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.nack_seen |-> result.bus_command == CMD_STOP)
		else $error("nack_seen outside a stop step");

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bus_command == CMD_STOP |-> !result.busy_res)
		else $error("busy after stop");

	a_fetch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.fetched_byte != 8'h00 |-> result.bus_command == CMD_NONE)
		else $error("bus command alongside fetched byte");

	a_len_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.frame_count <= BUF_LEN_MAX)
		else $error("frame_count beyond buffer depth");

endmodule

bind rfid_reader_i2c_sequencer_top rfidseq_checker u_rfidseq_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the RFID reader I2C sequencer top level.
// Drives item transfers, predicts every result in step with the block and
// checks each result transfer field by field. Depends on rfidseq_pkg.
`timescale 1ns / 1ps

module testbench;
	import rfidseq_pkg::*;

	// Operation code 7 is not in op_t; the block must ignore it.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// Per-phase item counts for the random traffic.
	localparam int PHASE_ITEMS = 300;
	localparam int HOLD_CYCLES = 80;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    cfg_wr_en    = 1'b0;
	logic [6:0] cfg_wr_data = 7'h00;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	always #6 clk = ~clk;

	rfid_reader_i2c_sequencer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// ------------------------------------------------------------------
	// Predicted sequencer state. Updated once per accepted item transfer,
	// in the sending task, so the state is always current when the
	// stimulus code looks at it to decide the next item.
	// ------------------------------------------------------------------
	step_t            seq_step = ST_IDLE;
	logic [7:0]       shadow_buf [BUF_DEPTH];
	logic [LEN_W-1:0] shadow_len = '0;
	logic [LEN_W-1:0] shadow_pos = '0;
	logic [6:0]       shadow_addr = DEV_ADDR_RESET;

	result_t pending_results[$];
	result_t oldest_result;
	int      items_sent    = 0;
	int      mismatches    = 0;
	int      send_idle_pct = 0;
	int      stall_pct     = 0;
	int      hold_req      = 0;
	int      hold_left     = 0;

	function automatic logic [LEN_W-1:0] clamp_to_depth(input logic [7:0] v);
		return (v > BUF_DEPTH) ? LEN_W'(BUF_DEPTH) : v[LEN_W-1:0];
	endfunction

	// Steps are one-hot and numbered in sequence order, so the next step
	// of a linear run is a shift left by one.
	function automatic step_t following(input step_t s);
		return step_t'(s << 1);
	endfunction

	// Works out the result of one accepted item and advances the shadow
	// state, then queues the result as the next one owed by the block.
	task automatic predict_bus_result(input item_t it);
		result_t r;
		logic [LEN_W:0] pos_next;
		r = '0;
		case (it.operation)
		OP_READ_PARAM:  seq_step = ST_RP0;
		OP_WRITE_PARAM: begin
			shadow_buf[0] = it.host_byte;
			seq_step = ST_WP0;
		end
		OP_READ_FRAME:  seq_step = ST_RF0;
		OP_WRITE_FRAME: begin
			shadow_len = clamp_to_depth(it.send_length);
			seq_step = ST_WF0;
		end
		OP_LOAD_BYTE:   shadow_buf[it.buffer_slot] = it.host_byte;
		OP_FETCH_BYTE:  r.fetched_byte = shadow_buf[it.buffer_slot];
		OP_BUS_READY: begin
			case (seq_step)
			ST_RP0, ST_WP0, ST_RF0, ST_WF0: begin
				r.bus_command = CMD_START;
				seq_step = following(seq_step);
			end
			ST_RP1, ST_WP1, ST_RF1, ST_WF1: begin
				r.bus_command = CMD_ADDR_WR;
				r.bus_byte = {1'b0, shadow_addr};
				seq_step = following(seq_step);
			end
			ST_RP4, ST_RF4: begin
				r.bus_command = CMD_ADDR_RD;
				r.bus_byte = {1'b0, shadow_addr};
				seq_step = following(seq_step);
			end
			ST_RP2, ST_WP2: begin
				r.bus_command = CMD_WRITE;
				r.bus_byte = REG_PARAM;
				seq_step = following(seq_step);
			end
			ST_RF2, ST_WF2: begin
				r.bus_command = CMD_WRITE;
				r.bus_byte = REG_FRAME;
				seq_step = following(seq_step);
			end
			ST_RP3, ST_RF3: begin
				r.bus_command = CMD_RESTART;
				seq_step = following(seq_step);
			end
			ST_RP5: begin
				r.bus_command = CMD_READ_NACK;
				seq_step = ST_RP6;
			end
			ST_RP6: begin
				// parameter byte lands in slot 0
				shadow_buf[0] = it.received_byte;
				r.bus_command = CMD_STOP;
				seq_step = ST_IDLE;
			end
			ST_WP3: begin
				r.bus_command = CMD_WRITE;
				r.bus_byte = shadow_buf[0];
				seq_step = ST_WP4;
			end
			ST_WP4, ST_WF5: begin
				r.nack_seen = ~it.slave_acked;
				r.bus_command = CMD_STOP;
				seq_step = ST_IDLE;
			end
			ST_RF5: begin
				r.bus_command = CMD_READ_ACK;
				seq_step = ST_RF6;
			end
			ST_RF6: begin
				// length byte: zero goes to the dummy NACKed read
				shadow_len = clamp_to_depth(it.received_byte);
				if (shadow_len == 0) begin
					seq_step = ST_RF9;
				end else begin
					shadow_pos = '0;
					seq_step = ST_RF7;
				end
			end
			ST_RF7: begin
				if (shadow_pos < shadow_len) begin
					pos_next = {1'b0, shadow_pos} + 1'b1;
					r.bus_command = (pos_next < {1'b0, shadow_len}) ?
						CMD_READ_ACK : CMD_READ_NACK;
					seq_step = ST_RF8;
				end else begin
					seq_step = ST_RF10;
				end
			end
			ST_RF8: begin
				shadow_buf[shadow_pos[IDX_W-1:0]] = it.received_byte;
				shadow_pos = shadow_pos + 1'b1;
				seq_step = ST_RF7;
			end
			ST_RF9: begin
				r.bus_command = CMD_READ_NACK;
				seq_step = ST_RF10;
			end
			ST_RF10: begin
				r.bus_command = CMD_STOP;
				seq_step = ST_IDLE;
			end
			ST_WF3: begin
				r.bus_command = CMD_WRITE;
				r.bus_byte = {4'h0, shadow_len};
				shadow_pos = '0;
				seq_step = ST_WF4;
			end
			ST_WF4: begin
				if (shadow_pos < shadow_len) begin
					r.bus_command = CMD_WRITE;
					r.bus_byte = shadow_buf[shadow_pos[IDX_W-1:0]];
					shadow_pos = shadow_pos + 1'b1;
				end else begin
					seq_step = ST_WF5;
				end
			end
			default: seq_step = ST_IDLE;
			endcase
		end
		default: ;
		endcase
		r.busy_res = (seq_step != ST_IDLE);
		r.frame_count = shadow_len;
		pending_results.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Item side. Valid is raised at a rising edge and held, payload fixed,
	// until the edge at which stall is low. Random idle cycles follow an
	// accepted transfer according to send_idle_pct.
	// ------------------------------------------------------------------
	task automatic send_item(input item_t it);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		predict_bus_result(it);
		items_sent++;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic item_t rand_item(input logic [2:0] op);
		item_t it;
		it.operation     = op;
		it.host_byte     = 8'($urandom_range(255));
		it.buffer_slot   = IDX_W'($urandom_range(BUF_DEPTH - 1));
		it.send_length   = 8'($urandom_range(255));
		it.received_byte = 8'($urandom_range(255));
		it.slave_acked   = 1'($urandom_range(1));
		return it;
	endfunction

	// A bus_ready step; the length byte of a frame read is kept mostly
	// short so that both the zero case and real reads come up often.
	function automatic item_t bus_ready_item();
		item_t it;
		it = rand_item(OP_BUS_READY);
		if (seq_step == ST_RF6 && $urandom_range(3) != 0)
			it.received_byte = 8'($urandom_range(BUF_DEPTH + 2));
		return it;
	endfunction

	// Stops offering and waits until the block owes nothing.
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Runs any open sequence to its stop step so the block is idle.
	task automatic settle();
		while (seq_step != ST_IDLE)
			send_item(bus_ready_item());
	endtask

	// Address changes only with the sequencer idle and nothing in flight.
	task automatic change_device_address(input logic [6:0] addr);
		settle();
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		shadow_addr = addr;
	endtask

	// One well-formed transaction with random content. Now and then a host
	// access or an unused code is slipped in mid-sequence, or a fresh
	// command cuts the running one short.
	task automatic run_transaction();
		item_t it;
		int    roll;
		it = rand_item(3'($urandom_range(OP_READ_PARAM, OP_WRITE_FRAME)));
		if ($urandom_range(3) != 0)
			it.send_length = 8'($urandom_range(BUF_DEPTH + 2));
		send_item(it);
		while (seq_step != ST_IDLE) begin
			roll = $urandom_range(99);
			if (roll < 2) begin
				send_item(rand_item(3'($urandom_range(OP_READ_PARAM, OP_WRITE_FRAME))));
			end else if (roll < 6) begin
				case ($urandom_range(2))
				0:       send_item(rand_item(OP_LOAD_BYTE));
				1:       send_item(rand_item(OP_FETCH_BYTE));
				default: send_item(rand_item(OP_UNUSED));
				endcase
			end else begin
				send_item(bus_ready_item());
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result side. Stall is drawn per cycle, except during a long hold
	// requested by the back-pressure test, which this process counts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req <= 0;
		end
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			mismatches++;
		end
	endtask

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: %p", result);
				mismatches++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("bus_command", 8'(oldest_result.bus_command),
					8'(result.bus_command));
				check_field("bus_byte", oldest_result.bus_byte, result.bus_byte);
				check_field("busy_res", 8'(oldest_result.busy_res),
					8'(result.busy_res));
				check_field("nack_seen", 8'(oldest_result.nack_seen),
					8'(result.nack_seen));
				check_field("fetched_byte", oldest_result.fetched_byte,
					result.fetched_byte);
				check_field("frame_count", 8'(oldest_result.frame_count),
					8'(result.frame_count));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Fills every slot (buffer is not cleared at reset), then reads back
	// both ends of the buffer.
	task automatic test_buffer_access();
		item_t it;
		for (int s = 0; s < BUF_DEPTH; s++) begin
			it = rand_item(OP_LOAD_BYTE);
			it.buffer_slot = IDX_W'(s);
			if (s == 0)
				it.host_byte = 8'h00;
			else if (s == BUF_DEPTH - 1)
				it.host_byte = 8'hFF;
			send_item(it);
		end
		it = rand_item(OP_FETCH_BYTE);
		it.buffer_slot = '0;
		send_item(it);
		it.buffer_slot = IDX_W'(BUF_DEPTH - 1);
		send_item(it);
	endtask

	// Unused operation code and a bus_ready with no sequence running.
	task automatic test_idle_items();
		send_item(rand_item(OP_UNUSED));
		send_item(rand_item(OP_BUS_READY));
	endtask

	// Over-long frame write cut short by a parameter read, with a host
	// fetch in the middle of the frame write; the read then completes.
	task automatic test_command_replace();
		item_t it;
		it = rand_item(OP_WRITE_FRAME);
		it.send_length = 8'hFF;
		send_item(it);
		repeat (3) send_item(rand_item(OP_BUS_READY));
		send_item(rand_item(OP_FETCH_BYTE));
		send_item(rand_item(OP_READ_PARAM));
		while (seq_step != ST_IDLE) begin
			it = rand_item(OP_BUS_READY);
			it.received_byte = 8'hFF;
			send_item(it);
		end
	endtask

	task automatic test_random_traffic(input int send_idle, input int stall,
			input int count);
		int target;
		send_idle_pct = send_idle;
		stall_pct     = stall;
		target        = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(99) < 85)
				run_transaction();
			else
				send_item(rand_item(3'($urandom_range(OP_UNUSED))));
		end
	endtask

	// Long receiver hold with the sender pushing flat out, so the block
	// backs up and stalls its input; then a full pause until empty.
	task automatic test_backpressure();
		int target;
		send_idle_pct = 0;
		stall_pct     = 0;
		settle();
		hold_req <= HOLD_CYCLES;
		target = items_sent + 40;
		while (items_sent < target)
			run_transaction();
		drain();
		repeat (3) run_transaction();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset address
		test_buffer_access();
		test_idle_items();
		test_command_replace();

		// random phases: no idling, sender idle, receiver stalling, both
		test_random_traffic(0, 0, PHASE_ITEMS);
		change_device_address(7'h7F);
		test_random_traffic(82, 0, PHASE_ITEMS);
		change_device_address(7'h00);
		test_random_traffic(0, 82, PHASE_ITEMS);
		change_device_address(7'($urandom_range(127)));
		test_random_traffic(15, 15, PHASE_ITEMS);
		test_backpressure();

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog, well beyond the slowest legal run.
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
